// ===== sv/status_led_heartbeat_monitor_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef STATUS_LED_HEARTBEAT_MONITOR_MACROS_SVH
`define STATUS_LED_HEARTBEAT_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slhm_pkg.sv =====
`default_nettype none

package slhm_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    // Widths of the stream payloads.
    localparam int OP_W      = 3;
    localparam int CH_W      = 3;
    localparam int HOLD_W    = 16;
    localparam int PINS_W    = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] BEAT_TIMEOUT_RST  = 16'd200;
    localparam logic [7:0]  TIMEOUT_MASK_RST  = 8'd94;
    localparam logic [7:0]  ACTIVITY_MASK_RST = 8'd96;
    localparam logic [15:0] BLINK_HALF_RST    = 16'd250;
    localparam logic [7:0]  READY_MASK_RST    = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_BEAT       = 3'd1,
        OP_SET_HEALTH = 3'd2,
        OP_MARK       = 3'd3,
        OP_FATAL      = 3'd4,
        OP_CLOSE      = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEAT_TIMEOUT  = 3'd0,
        CFG_TIMEOUT_MASK  = 3'd1,
        CFG_ACTIVITY_MASK = 3'd2,
        CFG_BLINK_HALF    = 3'd3,
        CFG_READY_MASK    = 3'd4
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== sv/status_led_heartbeat_monitor.sv =====
`default_nettype none

// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+-------------------------------------------
// s_*       | in  | s_tvalid / s_tready  | s_tuser: operation; s_tdata: channel, healthy, hold_ms
// m_*       | out | m_tvalid / m_tready  | m_tdata: led_pins, health_flags, fatal_flag
// cfg_*     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An accepted beat is processed while it sits in the input register, and its
// result is written to the result register once that register is free or draining.
// While m_tready stays high the block sustains one beat per cycle; the per-channel
// compare lanes all fit in the single combinational pass between the two registers.
// When the result register is held by a low m_tready, the input register holds too and
// s_tready drops only once both are full.
// Reset (rst_n low, asynchronous) restores the configuration defaults and the idle state.
module status_led_heartbeat_monitor #(
    parameter int CHANNELS = slhm_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // From bit 0: channel[2:0], healthy[3], hold_ms[19:4], zero fill[23:20].
    input  wire logic [slhm_pkg::S_TDATA_W-1:0]  s_tdata,
    // Operation code, bits [2:0].
    input  wire logic [slhm_pkg::OP_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // From bit 0: led_pins[7:0], health_flags[15:8], fatal_flag[16], zero fill[23:17].
    output logic [slhm_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [slhm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slhm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slhm_pkg::*;

    // The last channel is the fault indicator.
    localparam int FAULT_CH = CHANNELS - 1;
    localparam logic [CHANNELS-1:0] FAULT_BIT  = CHANNELS'(1) << FAULT_CH;
    localparam logic [CHANNELS-1:0] HEALTH_RST = CHANNELS'(1) | FAULT_BIT;

    // Configuration registers.
    logic [15:0] beat_timeout_reg;
    logic [7:0]  timeout_mask_reg;
    logic [7:0]  activity_mask_reg;
    logic [15:0] blink_half_reg;
    logic [7:0]  ready_mask_reg;

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [OP_W-1:0]   in_op_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic              in_healthy_reg;
    logic [HOLD_W-1:0] in_hold_reg;

    // Block state.
    logic [31:0]         clock_reg;
    logic [31:0]         clock_next;
    logic [15:0]         blink_cnt_reg;
    logic [15:0]         blink_cnt_next;
    logic                phase_reg;
    logic                phase_next;
    logic [CHANNELS-1:0] health_reg;
    logic [CHANNELS-1:0] health_next;
    logic [31:0]         beat_reg [CHANNELS];
    logic [31:0]         beat_next [CHANNELS];
    logic [31:0]         deadline_reg [CHANNELS];
    logic [31:0]         deadline_next [CHANNELS];
    logic                fatal_reg;
    logic                fatal_next;
    logic [CHANNELS-1:0] led_reg;
    logic [CHANNELS-1:0] led_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [PINS_W-1:0] out_led_reg;
    logic [PINS_W-1:0] out_health_reg;
    logic              out_fatal_reg;

    // Datapath signals.
    logic                advance;
    logic [31:0]         mask_wide [3];
    logic [CHANNELS-1:0] tmask;
    logic [CHANNELS-1:0] amask;
    logic [CHANNELS-1:0] rmask;
    logic [31:0]         clock_inc;
    logic [15:0]         cnt_inc;
    logic                tick_phase;
    logic [31:0]         ch_wide;
    logic [CHANNELS-1:0] ch_sel;
    logic [CHANNELS-1:0] tick_health;
    logic [CHANNELS-1:0] tick_levels;
    logic [31:0]         lane_age [CHANNELS];
    logic [31:0]         lane_left [CHANNELS];
    logic [31:0]         led_wide;
    logic [31:0]         health_wide;

    // The item in the input register moves on whenever the result register is free
    // or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Channel masks at the channel count.
    always_comb
    begin
        mask_wide[0] = {24'd0, timeout_mask_reg};
        mask_wide[1] = {24'd0, activity_mask_reg};
        mask_wide[2] = {24'd0, ready_mask_reg};
    end
    assign tmask = mask_wide[0][CHANNELS-1:0];
    assign amask = mask_wide[1][CHANNELS-1:0];
    assign rmask = mask_wide[2][CHANNELS-1:0];

    // Millisecond clock and blink divider as they stand after a tick.
    assign clock_inc  = clock_reg + 32'd1;
    assign cnt_inc    = blink_cnt_reg + 16'd1;
    assign tick_phase = (cnt_inc >= blink_half_reg) ? !phase_reg : phase_reg;

    // One lane per channel: beat age and remaining activity window after the tick.
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            lane_age[i]  = clock_inc - beat_reg[i];
            lane_left[i] = deadline_reg[i] - clock_inc;
        end
    end

    // Health after the watchdog check, and the level each lane asks for on a tick.
    // An active window is a remaining time that is nonzero and positive when taken
    // as a signed 32-bit value; in the window the lane shows the inverted blink phase.
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            tick_health[i] = health_reg[i];
            if (tmask[i] && health_reg[i] && (lane_age[i] > {16'd0, beat_timeout_reg}))
            begin
                tick_health[i] = 1'b0;
            end
            tick_levels[i] = tick_health[i];
            if (tick_health[i] && amask[i] && (lane_left[i] != 32'd0) && !lane_left[i][31])
            begin
                tick_levels[i] = !tick_phase;
            end
            if ((i == FAULT_CH) && fatal_reg)
            begin
                tick_levels[i] = 1'b0;
            end
        end
    end

    // Channel decode; a channel number at or above the channel count selects nothing.
    assign ch_wide = {29'd0, in_ch_reg};
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_sel[i] = (ch_wide == 32'(i));
        end
    end

    // Next state for the item in the input register.
    always_comb
    begin
        clock_next     = clock_reg;
        blink_cnt_next = blink_cnt_reg;
        phase_next     = phase_reg;
        health_next    = health_reg;
        beat_next      = beat_reg;
        deadline_next  = deadline_reg;
        fatal_next     = fatal_reg;
        led_next       = led_reg;
        unique case (in_op_reg)
            OP_TICK:
            begin
                clock_next     = clock_inc;
                blink_cnt_next = (cnt_inc >= blink_half_reg) ? 16'd0 : cnt_inc;
                phase_next     = tick_phase;
                health_next    = tick_health;
                led_next       = (led_reg & ~rmask) | (tick_levels & rmask);
            end
            OP_BEAT:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_sel[i])
                    begin
                        health_next[i] = 1'b1;
                        beat_next[i]   = clock_reg;
                    end
                end
            end
            OP_SET_HEALTH:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_sel[i])
                    begin
                        health_next[i] = in_healthy_reg;
                        if (in_healthy_reg)
                        begin
                            beat_next[i] = clock_reg;
                        end
                    end
                end
            end
            OP_MARK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_sel[i] && (in_hold_reg != '0))
                    begin
                        deadline_next[i] = clock_reg + {16'd0, in_hold_reg};
                    end
                end
            end
            OP_FATAL:
            begin
                fatal_next  = 1'b1;
                health_next = health_reg & ~FAULT_BIT;
                led_next    = led_reg & ~(rmask & FAULT_BIT);
            end
            OP_CLOSE:
            begin
                health_next = '0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    beat_next[i]     = 32'd0;
                    deadline_next[i] = 32'd0;
                end
                led_next = led_reg & ~rmask;
            end
            default:
            begin
                // Unused codes leave the state as it is.
            end
        endcase
    end

    // Result fields at their fixed eight-bit width.
    always_comb
    begin
        led_wide                   = '0;
        led_wide[CHANNELS-1:0]     = led_next;
        health_wide                = '0;
        health_wide[CHANNELS-1:0]  = health_next;
    end

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control, configuration and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_timeout_reg  <= BEAT_TIMEOUT_RST;
            timeout_mask_reg  <= TIMEOUT_MASK_RST;
            activity_mask_reg <= ACTIVITY_MASK_RST;
            blink_half_reg    <= BLINK_HALF_RST;
            ready_mask_reg    <= READY_MASK_RST;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            clock_reg         <= '0;
            blink_cnt_reg     <= '0;
            phase_reg         <= 1'b0;
            health_reg        <= HEALTH_RST;
            fatal_reg         <= 1'b0;
            led_reg           <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                beat_reg[i]     <= '0;
                deadline_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BEAT_TIMEOUT:  beat_timeout_reg  <= cfg_data;
                    CFG_TIMEOUT_MASK:  timeout_mask_reg  <= cfg_data[7:0];
                    CFG_ACTIVITY_MASK: activity_mask_reg <= cfg_data[7:0];
                    CFG_BLINK_HALF:    blink_half_reg    <= cfg_data;
                    CFG_READY_MASK:    ready_mask_reg    <= cfg_data[7:0];
                    default:
                    begin
                        // Indexes past the register list are dropped.
                    end
                endcase
            end
            if (advance)
            begin
                clock_reg     <= clock_next;
                blink_cnt_reg <= blink_cnt_next;
                phase_reg     <= phase_next;
                health_reg    <= health_next;
                beat_reg      <= beat_next;
                deadline_reg  <= deadline_next;
                fatal_reg     <= fatal_next;
                led_reg       <= led_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg      <= s_tuser;
            in_ch_reg      <= s_tdata[2:0];
            in_healthy_reg <= s_tdata[3];
            in_hold_reg    <= s_tdata[19:4];
        end
        if (advance)
        begin
            out_led_reg    <= led_wide[PINS_W-1:0];
            out_health_reg <= health_wide[PINS_W-1:0];
            out_fatal_reg  <= fatal_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_fatal_reg, out_health_reg, out_led_reg};

endmodule

`default_nettype wire

// ===== sv/slhm_checker.sv =====
`default_nettype none

`include "status_led_heartbeat_monitor_macros.svh"

module slhm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [slhm_pkg::M_TDATA_W-1:0] m_tdata
);
    import slhm_pkg::*;

    localparam int FATAL_BIT = 2 * PINS_W;

    // A stalled result beat keeps its value.
    `SLHM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // An accepted beat that reports the fatal latch is not directly followed by a valid beat without it.
    `SLHM_ASSERT_NEXT(a_fatal_sticky, clk, rst_n, m_tvalid && m_tready && m_tdata[FATAL_BIT], !m_tvalid || m_tdata[FATAL_BIT], "fatal flag dropped")

    // Once an accepted beat has passed through the input register, the result side is presenting a beat.
    `SLHM_ASSERT_NEXT(a_latency, clk, rst_n, s_tvalid && s_tready, ##1 m_tvalid, "result beat missing after accept")

    // While results drain, the input side is open.
    `SLHM_ASSERT_NOW(a_flow, clk, rst_n, m_tvalid && m_tready, s_tready, "input stalled while output drains")

endmodule

bind status_led_heartbeat_monitor slhm_checker u_slhm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/status_led_heartbeat_monitor_tb.sv =====
module status_led_heartbeat_monitor_tb;

    import slhm_pkg::*;

    // Clock period is 8 time units. The watchdog limit is far above the slowest correct run.
    // That run is about 2000 beats, each with idle gaps on either side drawn at random, plus
    // the input and result registers and the drains between register settings.
    localparam int RESET_CYCLES  = 12;
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTINGS_RUN  = 8;
    localparam int ITEMS_PER_RUN = 250;

    // These operation codes are outside the defined set. The block must treat them as
    // no-ops that still return the current status.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // This table holds the register settings, one for each random run. It includes the
    // extremes: a timeout of one and of 65535, a zero timeout and a zero blink half period
    // (both must behave as documented), and all-clear and all-set masks.
    // Run 5 replaces its row with random values.
    localparam logic [15:0] TIMEOUT_PLAN [SETTINGS_RUN] =
        '{16'd5, 16'd1, 16'hFFFF, 16'd20, 16'd0, 16'd0, 16'd10, 16'd8};
    localparam logic [7:0] WATCH_PLAN [SETTINGS_RUN] =
        '{8'hFF, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hC3, 8'hFF};
    localparam logic [7:0] BLINK_MASK_PLAN [SETTINGS_RUN] =
        '{8'hFF, 8'hA5, 8'hFF, 8'h0F, 8'hFF, 8'h00, 8'hFF, 8'hFF};
    localparam logic [15:0] HALF_PLAN [SETTINGS_RUN] =
        '{16'd2, 16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd1, 16'd5, 16'd4};
    localparam logic [7:0] READY_PLAN [SETTINGS_RUN] =
        '{8'hFF, 8'hFF, 8'h00, 8'hF0, 8'h3C, 8'hFF, 8'hFF, 8'hFF};

    // Fields of one result beat, packed from the top down so that pins sit in the low byte.
    typedef struct packed {
        logic       fatal;
        logic [7:0] health;
        logic [7:0] pins;
    } status_t;

    // The scoreboard keeps its own copy of the controller state and registers.
    // It predicts the status beat that each accepted stream beat causes and checks the
    // returned beats in order.
    class led_status_board;
        localparam int FAULT_CHANNEL = CHANNELS_DEFAULT - 1;

        logic [15:0] beat_timeout;
        logic [7:0]  watch_mask;
        logic [7:0]  blink_mask;
        logic [15:0] blink_half;
        logic [7:0]  ready_mask;

        logic [31:0] clock_ms;
        logic [15:0] blink_count;
        logic        blink_phase;
        logic [7:0]  health;
        logic [31:0] last_beat [CHANNELS_DEFAULT];
        logic [31:0] deadline [CHANNELS_DEFAULT];
        logic        fatal;
        logic [7:0]  pins;

        status_t expected_status [$];
        int      mismatches;
        int      compared;

        function new();
            beat_timeout = BEAT_TIMEOUT_RST;
            watch_mask   = TIMEOUT_MASK_RST;
            blink_mask   = ACTIVITY_MASK_RST;
            blink_half   = BLINK_HALF_RST;
            ready_mask   = READY_MASK_RST;
            clock_ms     = '0;
            blink_count  = '0;
            blink_phase  = 1'b0;
            health       = 8'h81;
            for (int i = 0; i < CHANNELS_DEFAULT; i++)
            begin
                last_beat[i] = '0;
                deadline[i]  = '0;
            end
            fatal      = 1'b0;
            pins       = '0;
            mismatches = 0;
            compared   = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [15:0] value);
            case (idx)
                CFG_BEAT_TIMEOUT:  beat_timeout = value;
                CFG_TIMEOUT_MASK:  watch_mask   = value[7:0];
                CFG_ACTIVITY_MASK: blink_mask   = value[7:0];
                CFG_BLINK_HALF:    blink_half   = value;
                CFG_READY_MASK:    ready_mask   = value[7:0];
                default: ;
            endcase
        endfunction

        // Pins without a ready bit keep their previous level.
        function void drive_pins(logic [7:0] levels);
            pins = (pins & ~ready_mask) | (levels & ready_mask);
        endfunction

        function void advance_ms();
            logic [7:0]  levels;
            logic [31:0] left;
            logic        lit;
            levels      = '0;
            clock_ms    = clock_ms + 32'd1;
            blink_count = blink_count + 16'd1;
            if (blink_count >= blink_half)
            begin
                blink_count = '0;
                blink_phase = ~blink_phase;
            end
            for (int i = 0; i < CHANNELS_DEFAULT; i++)
            begin
                if (watch_mask[i] && health[i] && (clock_ms - last_beat[i]) > {16'd0, beat_timeout})
                    health[i] = 1'b0;
                lit = health[i];
                // The activity window is open while the deadline lies ahead as a signed
                // 32-bit difference.
                if (lit && blink_mask[i])
                begin
                    left = deadline[i] - clock_ms;
                    if (left != 32'd0 && !left[31])
                        lit = ~blink_phase;
                end
                if (i == FAULT_CHANNEL && fatal)
                    lit = 1'b0;
                levels[i] = lit;
            end
            drive_pins(levels);
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch, logic hv,
                                logic [HOLD_W-1:0] hold);
            case (op)
                OP_TICK: advance_ms();
                OP_BEAT:
                begin
                    health[ch]    = 1'b1;
                    last_beat[ch] = clock_ms;
                end
                OP_SET_HEALTH:
                begin
                    health[ch] = hv;
                    if (hv)
                        last_beat[ch] = clock_ms;
                end
                OP_MARK:
                begin
                    if (hold != '0)
                        deadline[ch] = clock_ms + {16'd0, hold};
                end
                OP_FATAL:
                begin
                    fatal                 = 1'b1;
                    health[FAULT_CHANNEL] = 1'b0;
                    drive_pins(pins & ~(8'd1 << FAULT_CHANNEL));
                end
                OP_CLOSE:
                begin
                    health = '0;
                    for (int i = 0; i < CHANNELS_DEFAULT; i++)
                    begin
                        last_beat[i] = '0;
                        deadline[i]  = '0;
                    end
                    drive_pins(8'd0);
                end
                default: ;
            endcase
            expected_status.push_back('{fatal: fatal, health: health, pins: pins});
        endfunction

        function void check_status(logic [M_TDATA_W-1:0] word);
            status_t want;
            if (expected_status.size() == 0)
            begin
                $error("status beat with nothing expected: m_tdata=%h", word);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            compared++;
            if (word[7:0] !== want.pins)
            begin
                $error("led_pins: expected %h, actual %h", want.pins, word[7:0]);
                mismatches++;
            end
            if (word[15:8] !== want.health)
            begin
                $error("health_flags: expected %h, actual %h", want.health, word[15:8]);
                mismatches++;
            end
            if (word[16] !== want.fatal)
            begin
                $error("fatal_flag: expected %b, actual %b", want.fatal, word[16]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    led_status_board board;
    bit              steady;        // When set, neither side inserts idle cycles.
    int              sink_wait;
    int              cycles;
    int              items_sent;
    int              settings_used;

    status_led_heartbeat_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The watchdog ends a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // This block receives status beats. Every accepted beat is checked. A stall is then
    // drawn at random before the next beat may be taken. No stall is drawn while the
    // sender is in a steady stretch.
    always @(posedge clk)
    begin : status_sink
        int stall;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                board.check_status(m_tdata);
                stall = steady ? 0 : $urandom_range(0, 4);
                if (stall != 0)
                begin
                    m_tready  <= 1'b0;
                    sink_wait <= stall;
                end
            end
            else if (!m_tready)
            begin
                if (sink_wait <= 1)
                    m_tready <= 1'b1;
                sink_wait <= sink_wait - 1;
            end
        end
    end

    // This task presents one stream beat after a random gap and returns at the edge that
    // accepts it. Valid stays high on return, so the next call can follow with no bubble.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic hv, input logic [HOLD_W-1:0] hold);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, hold, hv, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_item(op, ch, hv, hold);
        items_sent++;
    endtask

    // The sender stops until every predicted status beat has been returned.
    // Each stream beat yields exactly one status beat, so the block is idle afterwards.
    task automatic drain_status();
        s_tvalid <= 1'b0;
        while (board.expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, value);
    endtask

    task automatic write_setting(input logic [15:0] timeout, input logic [15:0] watch,
                                 input logic [15:0] blinkers, input logic [15:0] half,
                                 input logic [15:0] ready);
        write_reg(CFG_BEAT_TIMEOUT, timeout);
        write_reg(CFG_TIMEOUT_MASK, watch);
        write_reg(CFG_ACTIVITY_MASK, blinkers);
        write_reg(CFG_BLINK_HALF, half);
        write_reg(CFG_READY_MASK, ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // The random mix is mostly ticks, beats and activity marks. Timeouts and blinking are
    // therefore exercised often. Closing and the spare codes appear rarely, and fatal
    // appears only where it is allowed. Hold times are mostly short so that windows open
    // and expire within a run.
    task automatic send_random(input bit fatal_allowed);
        int              pick;
        int              hold_pick;
        logic [OP_W-1:0] op;
        logic [15:0]     hold;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_TICK;
        else if (pick < 63)
            op = OP_BEAT;
        else if (pick < 76)
            op = OP_SET_HEALTH;
        else if (pick < 93)
            op = OP_MARK;
        else if (pick < 95)
            op = OP_CLOSE;
        else if (pick < 97)
            op = fatal_allowed ? OP_FATAL : OP_TICK;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        hold_pick = $urandom_range(0, 9);
        if (hold_pick == 0)
            hold = '0;
        else if (hold_pick < 3)
            hold = 16'($urandom_range(0, 65535));
        else
            hold = 16'($urandom_range(1, 40));
        send_item(op, CH_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), hold);
    endtask

    initial
    begin
        logic [15:0] timeout;
        logic [15:0] watch;
        logic [15:0] blinkers;
        logic [15:0] half;
        logic [15:0] ready;

        board = new();
        steady = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first directed part runs with the reset register values. Channels 0 and 7
        // start healthy. A long activity hold on channel 5 starts it blinking. A zero hold
        // on channel 6 must be ignored. The spare codes arrive once with every payload bit set
        // and once with none set, and must change nothing.
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_item(OP_BEAT, 3'd3, 1'b0, 16'd0);
        send_item(OP_SET_HEALTH, 3'd5, 1'b1, 16'd0);
        send_item(OP_SET_HEALTH, 3'd0, 1'b0, 16'd0);
        send_item(OP_MARK, 3'd5, 1'b0, 16'hFFFF);
        send_item(OP_MARK, 3'd6, 1'b1, 16'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_item(OP_SPARE_A, 3'd7, 1'b1, 16'hFFFF);
        send_item(OP_SPARE_B, 3'd0, 1'b0, 16'd0);
        send_item(OP_TICK, 3'd7, 1'b1, 16'hFFFF);
        drain_status();

        // The second directed part uses a zero timeout and a zero blink half period.
        // A watched channel therefore fails on the first tick after its beat, and the
        // blink phase flips on every tick. Pins outside the ready mask must hold their
        // level through the close.
        write_setting(16'd0, 16'h00FF, 16'h00FF, 16'd0, 16'h00A5);
        send_item(OP_BEAT, 3'd1, 1'b0, 16'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_item(OP_SET_HEALTH, 3'd2, 1'b1, 16'd0);
        send_item(OP_MARK, 3'd2, 1'b0, 16'd1);
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_item(OP_SET_HEALTH, 3'd4, 1'b1, 16'd0);
        send_item(OP_MARK, 3'd4, 1'b0, 16'd3);
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        send_item(OP_CLOSE, 3'd0, 1'b0, 16'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
        drain_status();

        // Each random run starts from a fresh register setting. Steady stretches with no
        // idling on either side are mixed at random with gappy ones. In odd runs the sender also
        // stops midway until every status beat is back. The last run latches fatal directly
        // and then leaves fatal in the random mix.
        for (int run = 0; run < SETTINGS_RUN; run++)
        begin
            timeout  = TIMEOUT_PLAN[run];
            watch    = {8'd0, WATCH_PLAN[run]};
            blinkers = {8'd0, BLINK_MASK_PLAN[run]};
            half     = HALF_PLAN[run];
            ready    = {8'd0, READY_PLAN[run]};
            if (run == 5)
            begin
                // The mask writes carry random upper bits, which the block must drop.
                timeout  = 16'($urandom_range(1, 30));
                watch    = 16'($urandom_range(0, 65535));
                blinkers = 16'($urandom_range(0, 65535));
                half     = 16'($urandom_range(1, 8));
                ready    = 16'($urandom_range(0, 65535));
            end
            write_setting(timeout, watch, blinkers, half, ready);
            if (run == SETTINGS_RUN - 1)
            begin
                send_item(OP_FATAL, 3'd7, 1'b1, 16'd0);
                send_item(OP_TICK, 3'd0, 1'b0, 16'd0);
                send_item(OP_FATAL, 3'd0, 1'b0, 16'd0);
            end
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                if (n % 50 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (run % 2 == 1 && n == ITEMS_PER_RUN / 2)
                    drain_status();
                send_random(run == SETTINGS_RUN - 1);
            end
            drain_status();
            steady = 1'b0;
        end

        // A late extra beat would show up as a status beat with nothing expected.
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d stream beats under %0d register settings.",
                 items_sent, settings_used);
        $display("Compared %0d status beats, %0d field mismatches.",
                 board.compared, board.mismatches);
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
